[rtl/dsf_pkg.sv]
package dsf_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 50;
    localparam int DIV_LANES  = 4;
    localparam int E_LANE     = 3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SAT       = 2'd1,
        ST_ZERO_REST = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] delta_pos_x;
        logic signed [31:0] delta_pos_y;
        logic signed [31:0] delta_pos_z;
        logic signed [31:0] delta_vel_x;
        logic signed [31:0] delta_vel_y;
        logic signed [31:0] delta_vel_z;
        logic        [31:0] rest_length;
        logic        [31:0] spring_stiffness;
        logic        [16:0] spring_damping;
        logic        [15:0] first_body_mask;
        logic        [15:0] second_body_mask;
    } t_req;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               skipped;
        t_status            status;
    } t_rsp;

    typedef struct packed {
        logic [63:0] s;
        logic [31:0] root;
        logic [33:0] rem;
    } t_sqrt;

    typedef struct packed {
        logic [31:0]          d;
        logic [31:0]          rem;
        logic [DIV_STEPS-1:0] nq;
    } t_div;

endpackage

[rtl/dsf_sqrt_cell.sv]
module dsf_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  dsf_pkg::t_sqrt i_cell,
    output dsf_pkg::t_sqrt o_cell
);
    import dsf_pkg::*;

    logic [35:0] w_part;
    logic [35:0] w_trial;
    t_sqrt       n_cell;
    t_sqrt       r_cell;

    assign w_part  = {i_cell.rem, i_cell.s[63:62]};
    assign w_trial = {2'b00, i_cell.root, 2'b01};

    always_comb begin
        n_cell.s = {i_cell.s[61:0], 2'b00};
        if (w_part >= w_trial) begin
            n_cell.rem  = 34'(w_part - w_trial);
            n_cell.root = {i_cell.root[30:0], 1'b1};
        end else begin
            n_cell.rem  = w_part[33:0];
            n_cell.root = {i_cell.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

[rtl/dsf_div_cell.sv]
module dsf_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  dsf_pkg::t_div i_cell,
    output dsf_pkg::t_div o_cell
);
    import dsf_pkg::*;

    logic [32:0] w_part;
    logic        w_ge;
    t_div        n_cell;
    t_div        r_cell;

    assign w_part = {i_cell.rem, i_cell.nq[DIV_STEPS-1]};
    assign w_ge   = (w_part >= {1'b0, i_cell.d});

    always_comb begin
        n_cell.d  = i_cell.d;
        n_cell.nq = {i_cell.nq[DIV_STEPS-2:0], w_ge};
        if (w_ge) begin
            n_cell.rem = 32'(w_part - {1'b0, i_cell.d});
        end else begin
            n_cell.rem = w_part[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

[rtl/damped_spring_force.sv]
// Damped spring force unit. Each request on the input channel describes one spring; the
// block returns one response with the force on the second body (the first body takes
// the negated vector), a skipped flag and a status code.
// Requests are taken with i_valid/o_ready and responses given with o_valid/i_ready.
// The group mask register is written through i_cfg_we/i_cfg_wdata; the user must write it
// only while the block is idle, not enforced by the block. A request passes from the
// accepting edge to o_valid through 91 registers: two for the squared length, 32 square
// root cells, one set-up register, 50 divider cells, five stages of multiply and round,
// and the output register. Throughput is one request per cycle; the chain of root and
// divider cells sets this. Every stage advances together whenever the output register is
// empty or being taken, so a stalled receiver holds the whole pipeline and o_ready falls
// with it. Reset clears all valid flags and sets the group mask to all ones; the data
// registers keep whatever they held.
module damped_spring_force (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dsf_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output dsf_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata
);
    import dsf_pkg::*;

    typedef struct packed {
        logic             skip;
        logic             zl0;
        logic [2:0]       dpneg;
        logic [2:0][31:0] dpmag;
        logic [2:0][31:0] dv;
        logic [31:0]      k;
        logic [17:0]      omd;
        logic [31:0]      l0;
    } t_sb1;

    typedef struct packed {
        logic             skip;
        logic             zl0;
        logic             lenz;
        logic             eneg;
        logic [2:0]       dpneg;
        logic [2:0][31:0] dv;
        logic [31:0]      k;
        logic [17:0]      omd;
    } t_sb2;

    typedef struct packed {
        logic skip;
        logic zl0;
        logic esat;
    } t_flags;

    logic        w_en;
    logic [15:0] r_group_mask;

    logic signed [31:0] w_dp_in [3];
    logic        [31:0] w_mag   [3];
    t_sb1               n_a_sb;

    logic        r_a_vld;
    logic [63:0] r_a_sq [3];
    t_sb1        r_a_sb;
    logic        r_b_vld;
    logic [63:0] r_b_sum;
    t_sb1        r_b_sb;

    t_sqrt w_sq     [SQRT_STEPS+1];
    logic  r_sq_vld [SQRT_STEPS];
    t_sb1  r_sq_sb  [SQRT_STEPS];

    logic [31:0] w_len;
    t_sb1        w_dsb;
    logic [31:0] w_ediff;
    logic [63:0] w_num [DIV_LANES];
    t_div        n_d_div [DIV_LANES];
    t_sb2        n_d_sb;
    logic        r_d_vld;
    t_div        r_d_div [DIV_LANES];
    t_sb2        r_d_sb;

    t_div w_dv     [DIV_LANES][DIV_STEPS+1];
    logic r_dv_vld [DIV_STEPS];
    t_sb2 r_dv_sb  [DIV_STEPS];

    t_sb2                 w_psb;
    logic signed [31:0]   w_u    [3];
    logic signed [31:0]   w_dvs  [3];
    logic [DIV_STEPS-1:0] w_qe;
    logic                 w_esat;
    logic signed [31:0]   w_e;

    logic               r_p1_vld;
    logic signed [63:0] r_p1_prod [3];
    logic signed [31:0] r_p1_u    [3];
    logic signed [31:0] r_p1_e;
    logic        [31:0] r_p1_k;
    logic signed [17:0] r_p1_omd;
    t_flags             r_p1_fl;

    logic signed [63:0] w_sum;
    logic        [63:0] w_sum_mag;
    logic        [33:0] w_rv_mag;
    logic signed [34:0] w_rv;

    logic               r_p2_vld;
    logic signed [34:0] r_p2_rv;
    logic signed [63:0] r_p2_ek;
    logic signed [31:0] r_p2_u [3];
    logic signed [17:0] r_p2_omd;
    t_flags             r_p2_fl;

    logic        [63:0] w_ek_mag;
    logic        [47:0] w_ekr_mag;

    logic               r_p3_vld;
    logic signed [52:0] r_p3_rvd;
    logic signed [47:0] r_p3_ekr;
    logic signed [31:0] r_p3_u [3];
    t_flags             r_p3_fl;

    logic        [52:0] w_rvd_mag;
    logic        [36:0] w_rvdr_mag;
    logic signed [49:0] w_rvdr;

    logic               r_p4_vld;
    logic signed [49:0] r_p4_s;
    logic signed [31:0] r_p4_u [3];
    t_flags             r_p4_fl;

    logic [49:0] w_smag_full;
    logic [48:0] w_smag;
    logic [30:0] w_umag [3];

    logic        r_p5_vld;
    logic [49:0] r_p5_hi  [3];
    logic [60:0] r_p5_lo  [3];
    logic        r_p5_neg [3];
    t_flags      r_p5_fl;

    logic [31:0]        w_lo_r  [3];
    logic [50:0]        w_t     [3];
    logic               w_fsat  [3];
    logic signed [31:0] w_force [3];
    t_rsp               n_out;
    logic               r_out_vld;
    t_rsp               r_out;

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_mask <= 16'hFFFF;
        end else if (i_cfg_we) begin
            r_group_mask <= i_cfg_wdata;
        end
    end

    assign w_dp_in[0] = i_req.delta_pos_x;
    assign w_dp_in[1] = i_req.delta_pos_y;
    assign w_dp_in[2] = i_req.delta_pos_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i]          = w_dp_in[i][31] ? 32'(32'd0 - w_dp_in[i]) : w_dp_in[i];
            n_a_sb.dpneg[i]   = w_dp_in[i][31];
            n_a_sb.dpmag[i]   = w_mag[i];
        end
        n_a_sb.dv[0] = i_req.delta_vel_x;
        n_a_sb.dv[1] = i_req.delta_vel_y;
        n_a_sb.dv[2] = i_req.delta_vel_z;
        n_a_sb.skip  = ((i_req.first_body_mask & i_req.second_body_mask & r_group_mask)
                        == 16'd0);
        n_a_sb.zl0   = (i_req.rest_length == 32'd0);
        n_a_sb.k     = i_req.spring_stiffness;
        n_a_sb.omd   = 18'(18'd65536 - {1'b0, i_req.spring_damping});
        n_a_sb.l0    = i_req.rest_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_d_vld  <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_p5_vld <= 1'b0;
            r_out_vld <= 1'b0;
            for (int j = 0; j < SQRT_STEPS; j++) begin
                r_sq_vld[j] <= 1'b0;
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dv_vld[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_a_vld     <= i_valid;
            r_b_vld     <= r_a_vld;
            r_sq_vld[0] <= r_b_vld;
            for (int j = 1; j < SQRT_STEPS; j++) begin
                r_sq_vld[j] <= r_sq_vld[j-1];
            end
            r_d_vld     <= r_sq_vld[SQRT_STEPS-1];
            r_dv_vld[0] <= r_d_vld;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
            r_p1_vld  <= r_dv_vld[DIV_STEPS-1];
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_p5_vld  <= r_p4_vld;
            r_out_vld <= r_p5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_sq[i] <= {32'd0, w_mag[i]} * {32'd0, w_mag[i]};
            end
            r_a_sb  <= n_a_sb;
            r_b_sum <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
            r_b_sb  <= r_a_sb;
            r_sq_sb[0] <= r_b_sb;
            for (int j = 1; j < SQRT_STEPS; j++) begin
                r_sq_sb[j] <= r_sq_sb[j-1];
            end
        end
    end

    assign w_sq[0] = '{s: r_b_sum, root: 32'd0, rem: 34'd0};

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        dsf_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cell (w_sq[g]),
            .o_cell (w_sq[g+1])
        );
    end

    assign w_len = w_sq[SQRT_STEPS].root;
    assign w_dsb = r_sq_sb[SQRT_STEPS-1];

    always_comb begin
        w_ediff = (w_len >= w_dsb.l0) ? 32'(w_len - w_dsb.l0) : 32'(w_dsb.l0 - w_len);
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {2'b00, w_dsb.dpmag[i], 30'd0} + {33'd0, w_len[31:1]};
            n_d_div[i].d   = w_len;
        end
        w_num[E_LANE]     = {16'd0, w_ediff, 16'd0} + {33'd0, w_dsb.l0[31:1]};
        n_d_div[E_LANE].d = w_dsb.l0;
        for (int i = 0; i < DIV_LANES; i++) begin
            n_d_div[i].rem = {18'd0, w_num[i][63:DIV_STEPS]};
            n_d_div[i].nq  = w_num[i][DIV_STEPS-1:0];
        end
        n_d_sb.skip  = w_dsb.skip;
        n_d_sb.zl0   = w_dsb.zl0;
        n_d_sb.lenz  = (w_len == 32'd0);
        n_d_sb.eneg  = (w_len < w_dsb.l0);
        n_d_sb.dpneg = w_dsb.dpneg;
        n_d_sb.dv    = w_dsb.dv;
        n_d_sb.k     = w_dsb.k;
        n_d_sb.omd   = w_dsb.omd;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < DIV_LANES; i++) begin
                r_d_div[i] <= n_d_div[i];
            end
            r_d_sb     <= n_d_sb;
            r_dv_sb[0] <= r_d_sb;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dv_sb[j] <= r_dv_sb[j-1];
            end
        end
    end

    for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
        assign w_dv[l][0] = r_d_div[l];
        for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
            dsf_div_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_cell (w_dv[l][g]),
                .o_cell (w_dv[l][g+1])
            );
        end
    end

    assign w_psb = r_dv_sb[DIV_STEPS-1];
    assign w_qe  = w_dv[E_LANE][DIV_STEPS].nq;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dvs[i] = $signed(w_psb.dv[i]);
            if (w_psb.lenz) begin
                w_u[i] = 32'sd0;
            end else if (w_psb.dpneg[i]) begin
                w_u[i] = $signed(32'(32'd0 - {1'b0, w_dv[i][DIV_STEPS].nq[30:0]}));
            end else begin
                w_u[i] = $signed({1'b0, w_dv[i][DIV_STEPS].nq[30:0]});
            end
        end
        w_esat = !w_psb.eneg && (w_qe[DIV_STEPS-1:31] != '0);
        if (w_esat) begin
            w_e = 32'sh7FFFFFFF;
        end else if (w_psb.eneg) begin
            w_e = $signed(32'(32'd0 - w_qe[31:0]));
        end else begin
            w_e = $signed(w_qe[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p1_prod[i] <= w_u[i] * w_dvs[i];
                r_p1_u[i]    <= w_u[i];
            end
            r_p1_e       <= w_e;
            r_p1_k       <= w_psb.k;
            r_p1_omd     <= $signed(w_psb.omd);
            r_p1_fl.skip <= w_psb.skip;
            r_p1_fl.zl0  <= w_psb.zl0;
            r_p1_fl.esat <= w_esat;
        end
    end

    always_comb begin
        w_sum     = r_p1_prod[0] + r_p1_prod[1] + r_p1_prod[2];
        w_sum_mag = w_sum[63] ? 64'(64'd0 - w_sum) : w_sum;
        w_rv_mag  = 34'((w_sum_mag + 64'd536870912) >> 30);
        w_rv      = w_sum[63] ? $signed(35'(35'd0 - {1'b0, w_rv_mag}))
                              : $signed({1'b0, w_rv_mag});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_rv  <= w_rv;
            r_p2_ek  <= r_p1_e * $signed({1'b0, r_p1_k});
            r_p2_u   <= r_p1_u;
            r_p2_omd <= r_p1_omd;
            r_p2_fl  <= r_p1_fl;
        end
    end

    always_comb begin
        w_ek_mag  = r_p2_ek[63] ? 64'(64'd0 - r_p2_ek) : r_p2_ek;
        w_ekr_mag = 48'((w_ek_mag + 64'd32768) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_rvd <= r_p2_rv * r_p2_omd;
            r_p3_ekr <= r_p2_ek[63] ? $signed(48'(48'd0 - w_ekr_mag)) : $signed(w_ekr_mag);
            r_p3_u   <= r_p2_u;
            r_p3_fl  <= r_p2_fl;
        end
    end

    always_comb begin
        w_rvd_mag  = r_p3_rvd[52] ? 53'(53'd0 - r_p3_rvd) : r_p3_rvd;
        w_rvdr_mag = 37'((w_rvd_mag + 53'd32768) >> 16);
        w_rvdr     = r_p3_rvd[52] ? $signed(50'(50'd0 - {13'd0, w_rvdr_mag}))
                                  : $signed({13'd0, w_rvdr_mag});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_s  <= 50'(r_p3_ekr) + w_rvdr;
            r_p4_u  <= r_p3_u;
            r_p4_fl <= r_p3_fl;
        end
    end

    always_comb begin
        w_smag_full = r_p4_s[49] ? 50'(50'd0 - r_p4_s) : r_p4_s;
        w_smag      = w_smag_full[48:0];
        for (int i = 0; i < 3; i++) begin
            w_umag[i] = r_p4_u[i][31] ? 31'(32'd0 - r_p4_u[i]) : r_p4_u[i][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p5_hi[i]  <= {31'd0, w_smag[48:30]} * {19'd0, w_umag[i]};
                r_p5_lo[i]  <= {31'd0, w_smag[29:0]} * {30'd0, w_umag[i]};
                r_p5_neg[i] <= r_p4_s[49] ^ r_p4_u[i][31];
            end
            r_p5_fl <= r_p4_fl;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lo_r[i] = 32'(({1'b0, r_p5_lo[i]} + 62'd536870912) >> 30);
            w_t[i]    = {1'b0, r_p5_hi[i]} + {19'd0, w_lo_r[i]};
            if (r_p5_neg[i]) begin
                w_fsat[i]  = (w_t[i] > 51'd2147483648);
                w_force[i] = w_fsat[i] ? 32'sh80000000 : $signed(32'(32'd0 - w_t[i][31:0]));
            end else begin
                w_fsat[i]  = (w_t[i][50:31] != 20'd0);
                w_force[i] = w_fsat[i] ? 32'sh7FFFFFFF : $signed(w_t[i][31:0]);
            end
        end
        n_out.skipped = r_p5_fl.skip;
        if (r_p5_fl.skip || r_p5_fl.zl0) begin
            n_out.force_x = 32'sd0;
            n_out.force_y = 32'sd0;
            n_out.force_z = 32'sd0;
        end else begin
            n_out.force_x = w_force[0];
            n_out.force_y = w_force[1];
            n_out.force_z = w_force[2];
        end
        if (r_p5_fl.skip) begin
            n_out.status = ST_OK;
        end else if (r_p5_fl.zl0) begin
            n_out.status = ST_ZERO_REST;
        end else if (r_p5_fl.esat || w_fsat[0] || w_fsat[1] || w_fsat[2]) begin
            n_out.status = ST_SAT;
        end else begin
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/dsf_check.sv]
module dsf_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input dsf_pkg::t_rsp o_rsp
);
    import dsf_pkg::*;

    // A skipped spring carries no force and a clean status.
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.skipped) |->
            (o_rsp.force_x == 32'sd0 && o_rsp.force_y == 32'sd0 &&
             o_rsp.force_z == 32'sd0 && o_rsp.status == ST_OK))
        else $error("skipped response with force or status");

    // A zero rest length gives zero force and is never also skipped.
    a_rest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_ZERO_REST) |->
            (!o_rsp.skipped && o_rsp.force_x == 32'sd0 &&
             o_rsp.force_y == 32'sd0 && o_rsp.force_z == 32'sd0))
        else $error("zero rest length response with force");

    // The block always takes a request while its output register is empty.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request refused with empty output");

    // A stalled response holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rsp)))
        else $error("stalled response changed");

endmodule

bind damped_spring_force dsf_check u_dsf_check (.*);
